### src/dmwc_pkg.sv
// Package for the dual multiply-with-carry generator with hashed seeding.
// Holds the field widths, the operation and register codes and the mixing constants.
// No dependencies; every other file of the block uses it.
package dmwc_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned StateW  = 64;
  localparam int unsigned CfgIdxW = 1;

  // Operation codes of an input beat.
  localparam logic OP_RESEED = 1'b0;
  localparam logic OP_NEXT   = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_MULT_FIRST  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_MULT_SECOND = 1'b1;

  // Reset values of the multipliers.
  localparam logic [WordW-1:0] MULT_FIRST_RESET  = 32'hffff0207;
  localparam logic [WordW-1:0] MULT_SECOND_RESET = 32'hffff4b9f;

  // Finaliser constants and per-generator salts.
  localparam logic [StateW-1:0] MIX_K1      = 64'hff51afd7ed558ccd;
  localparam logic [StateW-1:0] MIX_K2      = 64'hc4ceb9fe1a85ec53;
  localparam logic [StateW-1:0] SALT_FIRST  = 64'h9368e53c2f6af274;
  localparam logic [StateW-1:0] SALT_SECOND = 64'h586dcd208f7cd3fd;
  localparam int unsigned       MIX_SHIFT   = 33;

  // One xor-shift round of the finaliser.
  function automatic logic [StateW-1:0] xor_shift(input logic [StateW-1:0] x);
    return x ^ (x >> MIX_SHIFT);
  endfunction

endpackage

### src/dmwc_in_if.sv
// Input channel of the generator: valid/ready handshake with the operation and seeds.
// Depends on dmwc_pkg for the field widths.
interface dmwc_in_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [dmwc_pkg::WordW-1:0] seed_first;
  logic [dmwc_pkg::WordW-1:0] seed_second;

  modport source (output valid, operation, seed_first, seed_second, input ready);
  modport sink   (input valid, operation, seed_first, seed_second, output ready);
endinterface

### src/dmwc_out_if.sv
// Output channel of the generator: valid/ready handshake with the random value.
// Depends on dmwc_pkg for the field width.
interface dmwc_out_if;
  logic                       valid;
  logic                       ready;
  logic [dmwc_pkg::WordW-1:0] random_value;

  modport source (output valid, random_value, input ready);
  modport sink   (input valid, random_value, output ready);
endinterface

### src/dual_mwc_prng_hashed_seed.sv
// Top level: two 64-bit multiply-with-carry generators seeded through a 64-bit finaliser.
// All multiplications run through one shared 32x32 multiplier under a small sequencer.
// Depends on dmwc_pkg, dmwc_in_if and dmwc_out_if.
//
// Sequencing: a next beat steps the first generator, then the second, holding the last step
//   while the output register is full; no new beat is taken until the last is through. A reseed
//   runs the finaliser on each seed (twelve 32x32 products on the shared multiplier) before ready returns.
// Reset (rst_ni, asynchronous, active low): both states zero, multipliers at their defaults.
module dual_mwc_prng_hashed_seed (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dmwc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [dmwc_pkg::WordW-1:0]   cfg_data_i,
  dmwc_in_if.sink                      in_i,
  dmwc_out_if.source                   out_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MIX  = 2'd1;
  localparam logic [1:0] ST_NEXT = 2'd2;

  localparam int unsigned W = dmwc_pkg::WordW;
  localparam int unsigned S = dmwc_pkg::StateW;

  logic [1:0]   state_q, state_d;
  logic [3:0]   step_q, step_d;
  logic [W-1:0] mult_first_q, mult_second_q;
  logic [S-1:0] gen_first_q, gen_first_d;
  logic [S-1:0] gen_second_q, gen_second_d;
  logic [W-1:0] seed2_q, seed2_d;
  logic [S-1:0] v_q, v_d;
  logic [S-1:0] acc_q, acc_d;
  logic [S-1:0] prod_q;
  logic [W-1:0] out_data_q, out_data_d;
  logic         out_valid_q, out_valid_d;

  logic [W-1:0] mul_a, mul_b;
  logic [S-1:0] mul_p;
  logic [S-1:0] k_sel;
  logic [S-1:0] mix_sum;
  logic [S-1:0] v_new;
  logic [S-1:0] mwc_sum;
  logic         accept;

  assign accept       = in_i.valid && in_i.ready;
  assign in_i.ready   = (state_q == ST_IDLE);
  assign out_o.valid  = out_valid_q;
  assign out_o.random_value = out_data_q;

  // The shared multiplier.
  assign mul_p = S'(mul_a) * S'(mul_b);

  // Finaliser constant for the current half of the mix, and the product assembly.
  assign k_sel   = step_q[2] ? dmwc_pkg::MIX_K2 : dmwc_pkg::MIX_K1;
  assign mix_sum = {acc_q[S-1:W] + prod_q[W-1:0], acc_q[W-1:0]};
  assign v_new   = dmwc_pkg::xor_shift(mix_sum);

  // Carry step: the registered product plus the high half of the state being stepped.
  assign mwc_sum = prod_q + {{W{1'b0}}, (step_q[1:0] == 2'd1) ? gen_first_q[S-1:W]
                                                               : gen_second_q[S-1:W]};

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MIX: begin
        case (step_q[1:0])
          2'd0: begin
            mul_a = v_q[W-1:0];
            mul_b = k_sel[W-1:0];
          end
          2'd1: begin
            mul_a = v_q[W-1:0];
            mul_b = k_sel[S-1:W];
          end
          2'd2: begin
            mul_a = v_q[S-1:W];
            mul_b = k_sel[W-1:0];
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      ST_NEXT: begin
        if (step_q[1:0] == 2'd0) begin
          mul_a = mult_first_q;
          mul_b = gen_first_q[W-1:0];
        end else begin
          mul_a = mult_second_q;
          mul_b = gen_second_q[W-1:0];
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    gen_first_d  = gen_first_q;
    gen_second_d = gen_second_q;
    seed2_d      = seed2_q;
    v_d          = v_q;
    acc_d        = acc_q;
    out_data_d   = out_data_q;
    out_valid_d  = out_valid_q && !out_o.ready;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          step_d = '0;
          if (in_i.operation == dmwc_pkg::OP_RESEED) begin
            state_d = ST_MIX;
            seed2_d = in_i.seed_second;
            v_d     = dmwc_pkg::xor_shift(dmwc_pkg::SALT_FIRST ^
                                          {{W{1'b0}}, in_i.seed_first});
          end else begin
            state_d = ST_NEXT;
          end
        end
      end
      ST_MIX: begin
        step_d = step_q + 4'd1;
        case (step_q[1:0])
          2'd1: acc_d = prod_q;
          2'd2: acc_d = mix_sum;
          2'd3: begin
            v_d = v_new;
            // End of the second finaliser round: this seed's state is complete.
            if (step_q[2]) begin
              if (!step_q[3]) begin
                gen_first_d = v_new;
                v_d = dmwc_pkg::xor_shift(dmwc_pkg::SALT_SECOND ^ {{W{1'b0}}, seed2_q});
              end else begin
                gen_second_d = v_new;
                state_d      = ST_IDLE;
              end
            end
          end
          default: acc_d = acc_q;
        endcase
      end
      ST_NEXT: begin
        case (step_q[1:0])
          2'd0: step_d = 4'd1;
          2'd1: begin
            gen_first_d = mwc_sum;
            step_d      = 4'd2;
          end
          default: begin
            // Hold the last step until the output register is free.
            if (!out_valid_q || out_o.ready) begin
              gen_second_d = mwc_sum;
              out_data_d   = gen_first_q[W-1:0] + mwc_sum[W-1:0];
              out_valid_d  = 1'b1;
              state_d      = ST_IDLE;
            end
          end
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state, generator states and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      step_q        <= '0;
      gen_first_q   <= '0;
      gen_second_q  <= '0;
      out_valid_q   <= 1'b0;
      mult_first_q  <= dmwc_pkg::MULT_FIRST_RESET;
      mult_second_q <= dmwc_pkg::MULT_SECOND_RESET;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      gen_first_q  <= gen_first_d;
      gen_second_q <= gen_second_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dmwc_pkg::CFG_MULT_FIRST:  mult_first_q  <= cfg_data_i;
          dmwc_pkg::CFG_MULT_SECOND: mult_second_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    seed2_q    <= seed2_d;
    v_q        <= v_d;
    acc_q      <= acc_d;
    prod_q     <= mul_p;
    out_data_q <= out_data_d;
  end

endmodule

### src/dmwc_checker.sv
// Port-level checker for the dual multiply-with-carry generator, bound to the top level.
// Depends on dmwc_pkg for widths and operation codes.
module dmwc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       in_operation_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [dmwc_pkg::WordW-1:0] out_random_value_i
);

  logic accept;
  assign accept = in_valid_i && in_ready_i;

  // The block is busy straight after taking a beat.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_i)
    else $error("input ready directly after an accepted beat");

  // A reseed leaves the block still busy late in the mix.
  a_reseed_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_operation_i == dmwc_pkg::OP_RESEED) |=> ##14 !in_ready_i)
    else $error("reseed finished too early");

  // A next beat with a free output register shows its result once both generators have stepped.
  a_next_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_operation_i == dmwc_pkg::OP_NEXT) && !out_valid_i |=> ##3 out_valid_i)
    else $error("next beat gave no result in time");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_random_value_i))
    else $error("stalled result changed");

endmodule

bind dual_mwc_prng_hashed_seed dmwc_checker u_dmwc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .in_operation_i     (in_i.operation),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_random_value_i (out_o.random_value)
);
